// ===== hdl/ps2kc_pkg.sv =====
// ps2kc_pkg: types, command codes and reply bytes for the ps2 keyboard controller
// no dependencies; imported by ps2kc_fifo, ps2kc_ctrl and the core top level
`default_nettype none

package ps2kc_pkg;

   // access kind and port select codes
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;
   localparam logic PORT_DATA  = 1'b0;
   localparam logic PORT_CMD   = 1'b1;

   // controller commands
   localparam logic [7:0] CMD_GET_CONFIG   = 8'h20;
   localparam logic [7:0] CMD_SET_CONFIG   = 8'h60;
   localparam logic [7:0] CMD_AUX_OFF      = 8'ha7;
   localparam logic [7:0] CMD_AUX_ON       = 8'ha8;
   localparam logic [7:0] CMD_AUX_PORT_CHK = 8'ha9;
   localparam logic [7:0] CMD_CTRL_CHK     = 8'haa;
   localparam logic [7:0] CMD_KBD_PORT_CHK = 8'hab;
   localparam logic [7:0] CMD_KBD_OFF      = 8'had;
   localparam logic [7:0] CMD_KBD_ON       = 8'hae;
   localparam logic [7:0] CMD_READ_OUT     = 8'hd0;
   localparam logic [7:0] CMD_WRITE_OUT    = 8'hd1;
   localparam logic [7:0] CMD_WRITE_KBD    = 8'hd2;
   localparam logic [7:0] CMD_WRITE_AUXB   = 8'hd3;
   localparam logic [7:0] CMD_SEND_AUX     = 8'hd4;
   localparam logic [7:0] CMD_PULSE_FIRST  = 8'hf0;

   // keyboard commands
   localparam logic [7:0] KBD_RESET     = 8'hff;
   localparam logic [7:0] KBD_READ_ID   = 8'hf2;
   localparam logic [7:0] KBD_ECHO      = 8'hee;
   localparam logic [7:0] KBD_SET_LEDS  = 8'hed;
   localparam logic [7:0] KBD_SET_REP   = 8'hf3;
   localparam logic [7:0] KBD_SCAN_SET  = 8'hf0;

   // reply bytes
   localparam logic [7:0] RPL_ACK       = 8'hfa;
   localparam logic [7:0] RPL_BAT_OK    = 8'haa;
   localparam logic [7:0] RPL_ID_LO     = 8'hab;
   localparam logic [7:0] RPL_ID_HI     = 8'h83;
   localparam logic [7:0] RPL_SCAN_SET  = 8'h02;
   localparam logic [7:0] RPL_TEST_OK   = 8'h55;
   localparam logic [7:0] RPL_AUX_TEST  = 8'h01;
   localparam logic [7:0] RPL_ZERO      = 8'h00;

   // control byte and status byte
   localparam logic [7:0] CTR_RESET     = 8'h45;
   localparam logic [7:0] OUT_RESET     = 8'h03;
   localparam logic [7:0] CTR_AUX_DIS   = 8'h20;
   localparam logic [7:0] CTR_KBD_DIS   = 8'h10;
   localparam logic [7:0] STATUS_BASE   = 8'h14;
   localparam int         CTR_KBD_INT   = 0;
   localparam int         CTR_KBD_OFF   = 4;
   localparam int         STAT_OBF      = 0;
   localparam int         STAT_CMD_LAST = 3;

   typedef enum logic [2:0] {
      CTL_NONE  = 3'd0,
      CTL_WCTR  = 3'd1,
      CTL_WOUT  = 3'd2,
      CTL_WKBD  = 3'd3,
      CTL_WAUXB = 3'd4,
      CTL_WAUX  = 3'd5
   } ctl_op_type;

   typedef enum logic [1:0] {
      KOP_NONE = 2'd0,
      KOP_LEDS = 2'd1,
      KOP_REP  = 2'd2,
      KOP_SCAN = 2'd3
   } kbd_op_type;

   // request from the decoder to the reply fifo
   typedef struct packed {
      logic       flush;
      logic       pop;
      logic [1:0] n_push;
      logic [7:0] data0;
      logic [7:0] data1;
      logic [7:0] data2;
      logic       kbd;
   } fifo_cmd_type;

   // fifo view for the decoder
   typedef struct packed {
      logic       not_empty;
      logic [7:0] head_data;
      logic       nxt_not_empty;
      logic       nxt_head_kbd;
   } fifo_stat_type;

endpackage

`default_nettype wire

// ===== hdl/ps2kc_fifo.sv =====
// ps2kc_fifo: reply fifo taking up to three pushes, one pop or a flush per request
// depends on ps2kc_pkg
`default_nettype none

module ps2kc_fifo import ps2kc_pkg::*; #(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire fifo_cmd_type  cmd,
   output fifo_stat_type      stat
);

   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int SW = CW + 1;

   logic [7:0]    data_mem [FIFO_DEPTH];
   logic          kbd_mem  [FIFO_DEPTH];

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   logic [CW-1:0] base_count;
   logic [2:0]    push_en;
   logic [AW-1:0] slot [3];
   logic [7:0]    push_data [3];
   logic [SW-1:0] sum [3];
   logic [AW-1:0] head_inc;
   logic [CW-1:0] n_acc;

   always_comb begin
      base_count   = cmd.flush ? '0 : count_ff;
      push_data[0] = cmd.data0;
      push_data[1] = cmd.data1;
      push_data[2] = cmd.data2;
      n_acc        = '0;
      for (int i = 0; i < 3; i++) begin
         push_en[i] = (2'(i) < cmd.n_push) &&
                      ((SW'(base_count) + SW'(i)) < SW'(FIFO_DEPTH));
         sum[i]     = SW'(head_ff) + SW'(base_count) + SW'(i);
         if (sum[i] >= SW'(FIFO_DEPTH)) begin
            sum[i] = sum[i] - SW'(FIFO_DEPTH);
         end
         slot[i]    = sum[i][AW-1:0];
         n_acc      = n_acc + CW'(push_en[i]);
      end
   end

   // head plus one with wrap
   assign head_inc = (SW'(head_ff) == SW'(FIFO_DEPTH - 1)) ? '0 : head_ff + AW'(1);

   always_comb begin
      head_in  = head_ff;
      count_in = base_count + n_acc;
      if (cmd.pop && (count_ff != '0)) begin
         head_in  = head_inc;
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      stat.not_empty     = (count_ff != '0);
      stat.head_data     = data_mem[head_ff];
      stat.nxt_not_empty = (count_in != '0);
      if (cmd.pop) begin
         stat.nxt_head_kbd = kbd_mem[head_inc];
      end else if (base_count == '0) begin
         stat.nxt_head_kbd = cmd.kbd;
      end else begin
         stat.nxt_head_kbd = kbd_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (step) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // entries carry no reset, only pushed entries are ever popped
   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < 3; i++) begin
            if (push_en[i]) begin
               data_mem[slot[i]] <= push_data[i];
               kbd_mem[slot[i]]  <= cmd.kbd;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ps2kc_ctrl.sv =====
// ps2kc_ctrl: access decoder, controller and keyboard command state, interrupt line
// depends on ps2kc_pkg; drives the request side of ps2kc_fifo
`default_nettype none

module ps2kc_ctrl import ps2kc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic          in_kind,
   input  wire logic          in_port_select,
   input  wire logic [7:0]    in_write_data,
   input  wire fifo_stat_type fstat,
   output fifo_cmd_type       fcmd,
   output logic [7:0]         out_read_data,
   output logic               out_irq_level,
   output logic               out_irq_rise,
   output logic               out_reset_request
);

   logic [7:0] ctrl_ff, ctrl_in;
   logic [7:0] outp_ff, outp_in;
   logic       last_cmd_ff, last_cmd_in;
   ctl_op_type cop_ff, cop_in;
   kbd_op_type kop_ff, kop_in;
   logic       irq_ff, irq_in;

   always_comb begin
      ctrl_in           = ctrl_ff;
      outp_in           = outp_ff;
      last_cmd_in       = last_cmd_ff;
      cop_in            = cop_ff;
      kop_in            = kop_ff;
      fcmd              = '0;
      out_read_data     = '0;
      out_reset_request = 1'b0;

      if (in_kind == KIND_READ) begin
         if (in_port_select == PORT_DATA) begin
            fcmd.pop = fstat.not_empty;
            if (fstat.not_empty) begin
               out_read_data = fstat.head_data;
            end
         end else begin
            out_read_data                = STATUS_BASE;
            out_read_data[STAT_CMD_LAST] = last_cmd_ff;
            out_read_data[STAT_OBF]      = fstat.not_empty;
         end
      end else if (in_port_select == PORT_DATA) begin
         last_cmd_in = 1'b0;
         cop_in      = CTL_NONE;
         unique case (cop_ff)
            CTL_WCTR: ctrl_in = in_write_data;
            CTL_WOUT: begin
               outp_in           = in_write_data;
               out_reset_request = ~in_write_data[0];
            end
            CTL_WKBD: begin
               fcmd.n_push = 2'd1;
               fcmd.data0  = in_write_data;
               fcmd.kbd    = 1'b1;
            end
            CTL_WAUXB: begin
               fcmd.n_push = 2'd1;
               fcmd.data0  = in_write_data;
            end
            CTL_WAUX: ;
            default: begin
               // byte goes to the keyboard
               fcmd.kbd   = 1'b1;
               fcmd.data0 = RPL_ACK;
               fcmd.n_push = 2'd1;
               if (kop_ff != KOP_NONE) begin
                  kop_in = KOP_NONE;
                  if ((kop_ff == KOP_SCAN) && (in_write_data == 8'h00)) begin
                     fcmd.n_push = 2'd2;
                     fcmd.data1  = RPL_SCAN_SET;
                  end
               end else begin
                  unique case (in_write_data)
                     KBD_RESET: begin
                        fcmd.n_push = 2'd2;
                        fcmd.data1  = RPL_BAT_OK;
                     end
                     KBD_READ_ID: begin
                        fcmd.n_push = 2'd3;
                        fcmd.data1  = RPL_ID_LO;
                        fcmd.data2  = RPL_ID_HI;
                     end
                     KBD_ECHO:     fcmd.data0 = KBD_ECHO;
                     KBD_SET_LEDS: kop_in = KOP_LEDS;
                     KBD_SET_REP:  kop_in = KOP_REP;
                     KBD_SCAN_SET: kop_in = KOP_SCAN;
                     default: ;
                  endcase
               end
            end
         endcase
      end else begin
         // controller command, always flushes the replies
         last_cmd_in = 1'b1;
         fcmd.flush  = 1'b1;
         unique case (in_write_data)
            CMD_GET_CONFIG: begin
               fcmd.n_push = 2'd1;
               fcmd.data0  = ctrl_ff;
            end
            CMD_SET_CONFIG: cop_in = CTL_WCTR;
            CMD_WRITE_OUT:  cop_in = CTL_WOUT;
            CMD_WRITE_KBD:  cop_in = CTL_WKBD;
            CMD_WRITE_AUXB: cop_in = CTL_WAUXB;
            CMD_SEND_AUX:   cop_in = CTL_WAUX;
            CMD_AUX_OFF:    ctrl_in = ctrl_ff | CTR_AUX_DIS;
            CMD_AUX_ON:     ctrl_in = ctrl_ff & ~CTR_AUX_DIS;
            CMD_AUX_PORT_CHK: begin
               fcmd.n_push = 2'd1;
               fcmd.data0  = RPL_AUX_TEST;
            end
            CMD_CTRL_CHK: begin
               fcmd.n_push = 2'd1;
               fcmd.data0  = RPL_TEST_OK;
            end
            CMD_KBD_PORT_CHK: begin
               fcmd.n_push = 2'd1;
               fcmd.data0  = RPL_ZERO;
            end
            CMD_KBD_OFF:    ctrl_in = ctrl_ff | CTR_KBD_DIS;
            CMD_KBD_ON:     ctrl_in = ctrl_ff & ~CTR_KBD_DIS;
            CMD_READ_OUT: begin
               fcmd.n_push = 2'd1;
               fcmd.data0  = outp_ff;
            end
            default: begin
               // pulse command with the reset line bit low
               out_reset_request = (in_write_data >= CMD_PULSE_FIRST) & ~in_write_data[0];
            end
         endcase
      end
   end

   // line follows the head byte after the access; a pop drops it first
   assign irq_in        = fstat.nxt_not_empty & fstat.nxt_head_kbd &
                          ctrl_in[CTR_KBD_INT] & ~ctrl_in[CTR_KBD_OFF];
   assign out_irq_level = irq_in;
   assign out_irq_rise  = irq_in & (fcmd.pop | ~irq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff     <= CTR_RESET;
         outp_ff     <= OUT_RESET;
         last_cmd_ff <= 1'b0;
         cop_ff      <= CTL_NONE;
         kop_ff      <= KOP_NONE;
         irq_ff      <= 1'b0;
      end else if (step) begin
         ctrl_ff     <= ctrl_in;
         outp_ff     <= outp_in;
         last_cmd_ff <= last_cmd_in;
         cop_ff      <= cop_in;
         kop_ff      <= kop_in;
         irq_ff      <= irq_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ps2_keyboard_controller_core.sv =====
// ps2_keyboard_controller_core: top level of the ps2 keyboard controller
// depends on ps2kc_pkg, ps2kc_fifo and ps2kc_ctrl
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_ready  kind, port_select, write_data
//  rsp_     out        rsp_valid/rsp_ready  read byte, irq line, irq_rise, reset_request
//
// a request is held in an input register, decoded and applied to the state, and
// its response lands in the output register; one request per cycle sustained while
// responses are taken, the single decode-and-update pass sets this
// synchronous active high reset restores the control byte, output port, pending
// commands and empties the reply fifo; fifo entries carry no reset
// a stalled response holds the output register and the input register keeps
// taking a new request while its occupant can move into the output register
`default_nettype none

module ps2_keyboard_controller_core import ps2kc_pkg::*; #(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_kind,
   input  wire logic       req_port_select,
   input  wire logic [7:0] req_write_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_irq_level,
   output logic            rsp_irq_rise,
   output logic            rsp_reset_request
);

   // input register
   logic       in_vld_ff;
   logic       kind_ff;
   logic       port_ff;
   logic [7:0] wdata_ff;

   // output register
   logic       out_vld_ff;
   logic [7:0] rdata_ff, rdata_in;
   logic       irq_lvl_ff, irq_lvl_in;
   logic       irq_rise_ff, irq_rise_in;
   logic       rst_req_ff, rst_req_in;

   logic          step;
   fifo_cmd_type  fcmd;
   fifo_stat_type fstat;

   // request in the input register moves on when the output side has room
   assign step      = in_vld_ff & (~out_vld_ff | rsp_ready);
   assign req_ready = ~in_vld_ff | step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff  <= req_kind;
         port_ff  <= req_port_select;
         wdata_ff <= req_write_data;
      end
   end

   ps2kc_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .in_kind           (kind_ff),
      .in_port_select    (port_ff),
      .in_write_data     (wdata_ff),
      .fstat             (fstat),
      .fcmd              (fcmd),
      .out_read_data     (rdata_in),
      .out_irq_level     (irq_lvl_in),
      .out_irq_rise      (irq_rise_in),
      .out_reset_request (rst_req_in)
   );

   ps2kc_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .cmd   (fcmd),
      .stat  (fstat)
   );

   // response register, cleared once taken unless a new one arrives
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (step) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rdata_ff    <= rdata_in;
         irq_lvl_ff  <= irq_lvl_in;
         irq_rise_ff <= irq_rise_in;
         rst_req_ff  <= rst_req_in;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_read_data     = rdata_ff;
   assign rsp_irq_level     = irq_lvl_ff;
   assign rsp_irq_rise      = irq_rise_ff;
   assign rsp_reset_request = rst_req_ff;

endmodule

`default_nettype wire

// ===== sim/tb_ps2_keyboard_controller_core.sv =====
// tb_ps2_keyboard_controller_core: self-checking bench for the ps2 keyboard controller core
// depends on ps2kc_pkg and ps2_keyboard_controller_core; predicts every response in-bench
`timescale 1ns / 100ps

module tb_ps2_keyboard_controller_core;
   import ps2kc_pkg::*;

   localparam int FIFO_DEPTH   = 16;
   localparam int STALL_LIMIT  = 2000;  // cycles without any handshake before giving up
   localparam int SETTLE_CYCLES = 6;    // input and output registers plus margin

   // one predicted response per bus access
   typedef struct packed {
      logic [7:0] read_data;
      logic       line_level;
      logic       irq_rise;
      logic       reset_request;
   } access_result_type;

   // dut side
   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_kind = KIND_READ;
   logic       req_port_select = PORT_DATA;
   logic [7:0] req_write_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_irq_level;
   logic       rsp_irq_rise;
   logic       rsp_reset_request;

   // shadow of the controller state
   logic [7:0] ctr_byte;
   logic [7:0] out_port;
   logic       cmd_last;
   ctl_op_type ctl_pend;
   kbd_op_type kbd_pend;
   logic [7:0] fifo_byte [FIFO_DEPTH];
   logic       fifo_kbd [FIFO_DEPTH];
   int         fifo_head;
   int         fifo_count;
   logic       irq_line;
   logic       irq_rose;

   // responses still owed by the dut, oldest first
   access_result_type access_results [$];

   int error_count   = 0;
   int items_sent    = 0;
   int stall_cycles  = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int rsp_hold_len  = 0;

   ps2_keyboard_controller_core #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_port_select   (req_port_select),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_irq_level     (rsp_irq_level),
      .rsp_irq_rise      (rsp_irq_rise),
      .rsp_reset_request (rsp_reset_request)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic void reset_shadow();
      ctr_byte   = CTR_RESET;
      out_port   = OUT_RESET;
      cmd_last   = 1'b0;
      ctl_pend   = CTL_NONE;
      kbd_pend   = KOP_NONE;
      fifo_head  = 0;
      fifo_count = 0;
      irq_line   = 1'b0;
      irq_rose   = 1'b0;
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         fifo_byte[i] = 8'h00;
         fifo_kbd[i]  = 1'b0;
      end
   endfunction

   // any 0 -> 1 on the line within one access counts as a rising edge
   function automatic void drive_irq(input logic level);
      if (level && !irq_line)
         irq_rose = 1'b1;
      irq_line = level;
   endfunction

   // line follows a keyboard byte at the head while enabled and not disabled
   function automatic void refresh_irq();
      drive_irq(fifo_count != 0 && fifo_kbd[fifo_head] && ctr_byte[CTR_KBD_INT] &&
                !ctr_byte[CTR_KBD_OFF]);
   endfunction

   // a push into a full fifo is lost
   function automatic void push_reply(input logic [7:0] b, input logic kbd_src);
      int slot;
      if (fifo_count >= FIFO_DEPTH)
         return;
      slot = (fifo_head + fifo_count) % FIFO_DEPTH;
      fifo_byte[slot] = b;
      fifo_kbd[slot]  = kbd_src;
      fifo_count++;
      refresh_irq();
   endfunction

   function automatic access_result_type apply_bus_access(input logic kind, input logic port,
                                                           input logic [7:0] data);
      access_result_type res;
      ctl_op_type        cop;
      kbd_op_type        kop;
      res      = '0;
      irq_rose = 1'b0;
      if (kind == KIND_READ) begin
         if (port == PORT_DATA) begin
            // empty fifo reads zero and leaves everything alone
            if (fifo_count != 0) begin
               res.read_data = fifo_byte[fifo_head];
               fifo_head = (fifo_head + 1) % FIFO_DEPTH;
               fifo_count--;
               // the line drops and may come straight back for the next byte
               drive_irq(1'b0);
               refresh_irq();
            end
         end else begin
            res.read_data = STATUS_BASE;
            res.read_data[STAT_CMD_LAST] = cmd_last;
            res.read_data[STAT_OBF]      = (fifo_count != 0);
         end
      end else if (port == PORT_DATA) begin
         cmd_last = 1'b0;
         cop      = ctl_pend;
         ctl_pend = CTL_NONE;
         case (cop)
            CTL_WCTR: begin
               ctr_byte = data;
               refresh_irq();
            end
            CTL_WOUT: begin
               out_port = data;
               res.reset_request = !data[0];
            end
            CTL_WKBD:  push_reply(data, 1'b1);
            CTL_WAUXB: push_reply(data, 1'b0);
            CTL_WAUX: begin
               // parameter goes nowhere
            end
            default: begin
               // no controller parameter due: the byte goes to the keyboard
               if (kbd_pend != KOP_NONE) begin
                  kop      = kbd_pend;
                  kbd_pend = KOP_NONE;
                  push_reply(RPL_ACK, 1'b1);
                  if (kop == KOP_SCAN && data == 8'h00)
                     push_reply(RPL_SCAN_SET, 1'b1);
               end else begin
                  case (data)
                     KBD_RESET: begin
                        push_reply(RPL_ACK, 1'b1);
                        push_reply(RPL_BAT_OK, 1'b1);
                     end
                     KBD_READ_ID: begin
                        push_reply(RPL_ACK, 1'b1);
                        push_reply(RPL_ID_LO, 1'b1);
                        push_reply(RPL_ID_HI, 1'b1);
                     end
                     KBD_ECHO: push_reply(KBD_ECHO, 1'b1);
                     KBD_SET_LEDS: begin
                        kbd_pend = KOP_LEDS;
                        push_reply(RPL_ACK, 1'b1);
                     end
                     KBD_SET_REP: begin
                        kbd_pend = KOP_REP;
                        push_reply(RPL_ACK, 1'b1);
                     end
                     KBD_SCAN_SET: begin
                        kbd_pend = KOP_SCAN;
                        push_reply(RPL_ACK, 1'b1);
                     end
                     default: push_reply(RPL_ACK, 1'b1);
                  endcase
               end
            end
         endcase
      end else begin
         // every controller command flushes the fifo first
         cmd_last   = 1'b1;
         fifo_count = 0;
         drive_irq(1'b0);
         case (data)
            CMD_GET_CONFIG:   push_reply(ctr_byte, 1'b0);
            CMD_SET_CONFIG:   ctl_pend = CTL_WCTR;
            CMD_WRITE_OUT:    ctl_pend = CTL_WOUT;
            CMD_WRITE_KBD:    ctl_pend = CTL_WKBD;
            CMD_WRITE_AUXB:   ctl_pend = CTL_WAUXB;
            CMD_SEND_AUX:     ctl_pend = CTL_WAUX;
            CMD_AUX_OFF:      ctr_byte = ctr_byte | CTR_AUX_DIS;
            CMD_AUX_ON:       ctr_byte = ctr_byte & ~CTR_AUX_DIS;
            CMD_AUX_PORT_CHK: push_reply(RPL_AUX_TEST, 1'b0);
            CMD_CTRL_CHK:     push_reply(RPL_TEST_OK, 1'b0);
            CMD_KBD_PORT_CHK: push_reply(RPL_ZERO, 1'b0);
            CMD_KBD_OFF:      ctr_byte = ctr_byte | CTR_KBD_DIS;
            CMD_KBD_ON: begin
               ctr_byte = ctr_byte & ~CTR_KBD_DIS;
               refresh_irq();
            end
            CMD_READ_OUT:     push_reply(out_port, 1'b0);
            // even codes from the pulse range ask for a cpu reset, the rest do nothing
            default: res.reset_request = (data >= CMD_PULSE_FIRST) && !data[0];
         endcase
      end
      res.line_level = irq_line;
      res.irq_rise   = irq_rose;
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void flag_error(input string what, input logic [7:0] expv,
                                      input logic [7:0] actv);
      error_count++;
      if (error_count <= 10)
         $display("mismatch %0d at %0t: %s expected %h got %h", error_count, $realtime,
                  what, expv, actv);
   endfunction

   // each response is matched against the oldest outstanding prediction
   always @(posedge clock) begin : check_responses
      access_result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (access_results.size() == 0) begin
            flag_error("response with no request due", 8'h00, rsp_read_data);
         end else begin
            due = access_results.pop_front();
            if (rsp_read_data !== due.read_data)
               flag_error("read_data", due.read_data, rsp_read_data);
            if (rsp_irq_level !== due.line_level)
               flag_error("irq line", {7'h00, due.line_level}, {7'h00, rsp_irq_level});
            if (rsp_irq_rise !== due.irq_rise)
               flag_error("irq_rise", {7'h00, due.irq_rise}, {7'h00, rsp_irq_rise});
            if (rsp_reset_request !== due.reset_request)
               flag_error("reset_request", {7'h00, due.reset_request},
                          {7'h00, rsp_reset_request});
         end
      end
   end

   // receiver: random back-pressure, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (rsp_hold_len > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_len = rsp_hold_len - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: a long run with no handshake on either side means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles = stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // offer one request, hold it until taken, then record its predicted response
   task automatic send_request(input logic kind, input logic port, input logic [7:0] data);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_port_select <= port;
      req_write_data  <= data;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      access_results.push_back(apply_bus_access(kind, port, data));
      items_sent++;
   endtask

   // stop offering and wait for every outstanding response
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (access_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // reset values, empty read and reading back the control byte
   task automatic test_reset_state();
      send_request(KIND_READ, PORT_CMD, 8'hff);
      send_request(KIND_READ, PORT_DATA, 8'h00);
      send_request(KIND_WRITE, PORT_CMD, CMD_GET_CONFIG);
      send_request(KIND_READ, PORT_DATA, 8'hff);
   endtask

   // six id requests push eighteen bytes: the last two are dropped
   task automatic test_full_fifo();
      repeat (6)
         send_request(KIND_WRITE, PORT_DATA, KBD_READ_ID);
      send_request(KIND_READ, PORT_CMD, 8'h00);
      send_request(KIND_READ, PORT_DATA, 8'h00);
   endtask

   // pulse command and output port bit0 low both ask for a cpu reset
   task automatic test_reset_requests();
      send_request(KIND_WRITE, PORT_CMD, CMD_PULSE_FIRST | 8'h0e);
      // odd code in the pulse range is just an unknown command
      send_request(KIND_WRITE, PORT_CMD, CMD_PULSE_FIRST | 8'h0f);
      send_request(KIND_WRITE, PORT_CMD, CMD_WRITE_OUT);
      send_request(KIND_WRITE, PORT_DATA, 8'h00);
      send_request(KIND_WRITE, PORT_CMD, CMD_WRITE_OUT);
      send_request(KIND_WRITE, PORT_DATA, 8'hff);
      send_request(KIND_READ, PORT_CMD, 8'hff);
   endtask

   // aux write swallows its parameter; the next data byte reaches the keyboard
   task automatic test_aux_write();
      send_request(KIND_WRITE, PORT_CMD, CMD_SEND_AUX);
      send_request(KIND_WRITE, PORT_DATA, 8'ha5);
      send_request(KIND_WRITE, PORT_DATA, 8'h00);
      send_request(KIND_READ, PORT_DATA, 8'h00);
      send_request(KIND_READ, PORT_CMD, 8'h00);
   endtask

   // keyboard command, with its parameter where one is due
   task automatic send_keyboard_sequence();
      logic [7:0] kcmd;
      case ($urandom_range(6))
         0:       kcmd = KBD_RESET;
         1:       kcmd = KBD_READ_ID;
         2:       kcmd = KBD_ECHO;
         3:       kcmd = KBD_SET_LEDS;
         4:       kcmd = KBD_SET_REP;
         5:       kcmd = KBD_SCAN_SET;
         default: kcmd = 8'($urandom_range(255));
      endcase
      send_request(KIND_WRITE, PORT_DATA, kcmd);
      if (kcmd == KBD_SCAN_SET)
         send_request(KIND_WRITE, PORT_DATA,
                      ($urandom_range(1) != 0) ? 8'h00 : 8'($urandom_range(255)));
      else if (kcmd == KBD_SET_LEDS || kcmd == KBD_SET_REP)
         send_request(KIND_WRITE, PORT_DATA, 8'($urandom_range(255)));
   endtask

   // controller command, mostly followed by its parameter byte
   task automatic send_controller_sequence();
      logic [7:0] ccmd;
      logic [7:0] param;
      logic [2:0] pulse_sel;
      pulse_sel = 3'($urandom_range(7));
      case ($urandom_range(15))
         0:       ccmd = CMD_GET_CONFIG;
         1:       ccmd = CMD_SET_CONFIG;
         2:       ccmd = CMD_AUX_OFF;
         3:       ccmd = CMD_AUX_ON;
         4:       ccmd = CMD_AUX_PORT_CHK;
         5:       ccmd = CMD_CTRL_CHK;
         6:       ccmd = CMD_KBD_PORT_CHK;
         7:       ccmd = CMD_KBD_OFF;
         8:       ccmd = CMD_KBD_ON;
         9:       ccmd = CMD_READ_OUT;
         10:      ccmd = CMD_WRITE_OUT;
         11:      ccmd = CMD_WRITE_KBD;
         12:      ccmd = CMD_WRITE_AUXB;
         13:      ccmd = CMD_SEND_AUX;
         14:      ccmd = CMD_PULSE_FIRST | {4'h0, pulse_sel, 1'b0};
         default: ccmd = 8'($urandom_range(255));
      endcase
      send_request(KIND_WRITE, PORT_CMD, ccmd);
      param = 8'($urandom_range(255));
      // keep the keyboard interrupt enabled most of the time so the line moves
      if (ccmd == CMD_SET_CONFIG && $urandom_range(3) != 0) begin
         param[CTR_KBD_INT] = 1'b1;
         param[CTR_KBD_OFF] = 1'b0;
      end
      if ((ccmd == CMD_SET_CONFIG || ccmd == CMD_WRITE_OUT || ccmd == CMD_WRITE_KBD ||
           ccmd == CMD_WRITE_AUXB || ccmd == CMD_SEND_AUX) && $urandom_range(9) != 0)
         send_request(KIND_WRITE, PORT_DATA, param);
   endtask

   // mix of well-formed sequences, reads to drain replies, bursts and noise
   task automatic test_random_traffic(input int n_items);
      int target;
      int pick;
      target = items_sent + n_items;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 28)
            repeat ($urandom_range(1, 4))
               send_request(KIND_READ, PORT_DATA, 8'($urandom_range(255)));
         else if (pick < 36)
            send_request(KIND_READ, PORT_CMD, 8'($urandom_range(255)));
         else if (pick < 58)
            send_keyboard_sequence();
         else if (pick < 82)
            send_controller_sequence();
         else if (pick < 87)
            // burst of id requests to push the fifo to full
            repeat ($urandom_range(4, 7))
               send_request(KIND_WRITE, PORT_DATA, KBD_READ_ID);
         else
            send_request(1'($urandom_range(1)), 1'($urandom_range(1)),
                         8'($urandom_range(255)));
      end
   endtask

   // receiver holds off while the sender keeps offering, so the core backs up
   task automatic test_hold_off();
      int saved_pct;
      saved_pct     = send_idle_pct;
      send_idle_pct = 0;
      rsp_hold_len  = 60;
      repeat (10)
         send_request(KIND_WRITE, PORT_DATA, KBD_ECHO);
      repeat (10)
         send_request(KIND_READ, PORT_DATA, 8'($urandom_range(255)));
      send_idle_pct = saved_pct;
      drain_responses();
   endtask

   initial begin
      reset_shadow();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles lightly, receiver heavily
      send_idle_pct = 25;
      recv_idle_pct = 83;
      test_reset_state();
      test_full_fifo();
      test_reset_requests();
      test_aux_write();
      test_random_traffic(400);
      drain_responses();

      // the other way round
      send_idle_pct = 83;
      recv_idle_pct = 25;
      test_random_traffic(400);
      drain_responses();
      test_hold_off();

      // full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(400);
      drain_responses();

      if (access_results.size() != 0)
         flag_error("responses never arrived", 8'(access_results.size()), 8'h00);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
